// File: sv/losg_pkg.sv
// losg_pkg: shared types, CORDIC angle table and gain constant for the
// line-of-sight heading guidance pipeline. No dependencies.
`timescale 1ns / 1ps

package losg_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int DW = 40;   // datapath width, covers CORDIC growth of 33-bit offsets
  localparam int SW = 5;    // step index width

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] u;
    logic signed [DW-1:0] v;
    logic [31:0]          z;
    logic [31:0]          aux;
    logic signed [31:0]   err;
    logic                 degen;
    logic                 use_ge;
  } cordic_t;

  // atan(2^-i) in 32-bit binary angle units
  function automatic logic [31:0] arc_tab(input logic [SW-1:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // inverse CORDIC gain, Q30
  function automatic logic [29:0] inv_gain();
    logic [63:0] g;
    g = 64'd652039507;
    for (int i = 8; i < CORDIC_STEPS; i++) g = g - (g >> (2 * i + 1));
    return g[29:0];
  endfunction

  localparam logic [29:0] INV_GAIN = inv_gain();

endpackage

// File: sv/los_heading_guidance.sv
// los_heading_guidance: top level, line-of-sight heading guidance pipeline.
// Depends on losg_pkg and losg_cell.
`timescale 1ns / 1ps
//
// Channel | Signals                                    | Notes
// in      | in_valid / in_ready + seven fields + flag  | one transfer per item
// out     | out_valid / out_ready + three fields       | one transfer per item
// cfg     | cfg_we / cfg_wdata                          | lookahead, no wait
//
// Stages: prep, 16 path cells, gain multiply, error select, 16 lookahead
// cells, output register. One item per cycle while the output is not stalled.
// Reset clears the valid bits and sets lookahead to 10 m; data registers are not reset.
// A stalled output freezes the whole pipeline; in_ready drops with it.

module los_heading_guidance import losg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] vessel_north,
  input  logic signed [31:0] vessel_east,
  input  logic signed [31:0] path_point_x,
  input  logic signed [31:0] path_point_y,
  input  logic signed [31:0] tangent_x,
  input  logic signed [31:0] tangent_y,
  input  logic signed [31:0] given_error,
  input  logic               use_given_error,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] heading_ref,
  output logic signed [31:0] cross_track_error,
  output logic               degenerate_path,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_wdata
);

  logic [30:0] lookahead;
  logic        en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead <= 31'd655360;
    end else if (cfg_we) begin
      lookahead <= cfg_wdata;
    end
  end

  // ---- prep: offsets, half-plane fold (tangent x negative -> add pi) ----
  cordic_t prep_next;
  logic signed [DW-1:0] tx_e, ty_e, dx_e, dy_e;

  always_comb begin
    tx_e = DW'(tangent_x);
    ty_e = DW'(tangent_y);
    dx_e = DW'(vessel_north) - DW'(path_point_x);
    dy_e = DW'(vessel_east) - DW'(path_point_y);
    prep_next        = '0;
    prep_next.err    = given_error;
    prep_next.use_ge = use_given_error;
    prep_next.degen  = (tangent_x == 32'sd0) && (tangent_y == 32'sd0);
    if (tangent_x[31]) begin
      prep_next.x   = -tx_e;
      prep_next.y   = -ty_e;
      prep_next.u   = -dx_e;
      prep_next.v   = -dy_e;
      prep_next.aux = 32'h80000000;
    end else begin
      prep_next.x   = tx_e;
      prep_next.y   = ty_e;
      prep_next.u   = dx_e;
      prep_next.v   = dy_e;
    end
  end

  logic    c1_vld [0:CORDIC_STEPS];
  cordic_t c1_d   [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_vld[0] <= 1'b0;
    end else if (en) begin
      c1_vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_d[0] <= prep_next;
    end
  end

  // path-angle chain: vectors the tangent, rotates the offset with it
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_path
    losg_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .step(SW'(k)),
      .in_vld(c1_vld[k]), .in_d(c1_d[k]),
      .out_vld(c1_vld[k+1]), .out_d(c1_d[k+1])
    );
  end

  // ---- gain removal: |v| * INV_GAIN split into two partial products ----
  localparam int MW = DW - 3; // magnitude width
  logic [MW-1:0] mag;
  logic          mul_vld;
  cordic_t       mul_in;
  cordic_t       mul_d;
  logic [47:0]   p_lo;
  logic [48:0]   p_hi;
  logic          mul_neg;

  always_comb begin
    logic signed [DW-1:0] av;
    av  = c1_d[CORDIC_STEPS].v[DW-1] ? -c1_d[CORDIC_STEPS].v : c1_d[CORDIC_STEPS].v;
    mag = av[MW-1:0];
  end

  // alpha = fold base + path angle
  always_comb begin
    mul_in     = c1_d[CORDIC_STEPS];
    mul_in.aux = c1_d[CORDIC_STEPS].aux + c1_d[CORDIC_STEPS].z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
    end else if (en) begin
      mul_vld <= c1_vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_d     <= mul_in;
      mul_neg   <= c1_d[CORDIC_STEPS].v[DW-1];
      p_lo      <= {30'd0, mag[17:0]} * {18'd0, INV_GAIN};
      p_hi      <= {30'd0, mag[MW-1:18]} * {19'd0, INV_GAIN};
    end
  end

  // ---- error select and saturation, lookahead chain load ----
  logic [67:0]        prod;
  logic [37:0]        r;
  logic signed [31:0] err_sel;
  cordic_t            c2_in;

  always_comb begin
    prod = {1'b0, p_hi, 18'd0} + {20'd0, p_lo} + 68'(1) * 68'h20000000;
    r    = prod[67:30];
    if (mul_d.use_ge) begin
      err_sel = mul_d.err;
    end else if (mul_neg) begin
      err_sel = (r > 38'h80000000) ? 32'sh80000000 : -$signed(r[31:0]);
    end else begin
      err_sel = (r > 38'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(r[31:0]);
    end
    c2_in       = '0;
    c2_in.x     = (lookahead == 31'd0) ? DW'(1) : DW'(lookahead);
    c2_in.y     = DW'(err_sel);
    c2_in.err   = err_sel;
    c2_in.aux   = mul_d.aux;
    c2_in.degen = mul_d.degen;
  end

  logic    c2_vld [0:CORDIC_STEPS];
  cordic_t c2_d   [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_vld[0] <= 1'b0;
    end else if (en) begin
      c2_vld[0] <= mul_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_d[0] <= c2_in;
    end
  end

  // lookahead chain: atan2(error, lookahead)
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_los
    losg_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .step(SW'(k)),
      .in_vld(c2_vld[k]), .in_d(c2_d[k]),
      .out_vld(c2_vld[k+1]), .out_d(c2_d[k+1])
    );
  end

  // ---- output register: psi = pi/2 - alpha + los, rounded to 16 bits ----
  logic [31:0] psi;
  logic [31:0] psi_r;

  always_comb begin
    psi   = (32'h40000000 - c2_d[CORDIC_STEPS].aux) + c2_d[CORDIC_STEPS].z;
    psi_r = psi + 32'h00008000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c2_vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degenerate_path <= c2_d[CORDIC_STEPS].degen;
      if (c2_d[CORDIC_STEPS].degen) begin
        heading_ref       <= '0;
        cross_track_error <= '0;
      end else begin
        heading_ref       <= $signed(psi_r[31:16]);
        cross_track_error <= c2_d[CORDIC_STEPS].err;
      end
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate_path) |-> (heading_ref == 16'sd0 && cross_track_error == 32'sd0))
    else $error("degenerate result not zeroed");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> c1_vld[0])
    else $error("accepted item missing from first stage");

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled without a waiting result");

endmodule

// File: sv/losg_cell.sv
// losg_cell: one registered CORDIC micro-rotation. Vectors (x, y), rotates
// (u, v) the same way, accumulates z. Depends on losg_pkg.
`timescale 1ns / 1ps

module losg_cell import losg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [SW-1:0] step,
  input  logic          in_vld,
  input  cordic_t       in_d,
  output logic          out_vld,
  output cordic_t       out_d
);

  cordic_t d_next;

  always_comb begin
    d_next = in_d;
    if (!in_d.y[DW-1]) begin
      d_next.x = in_d.x + (in_d.y >>> step);
      d_next.y = in_d.y - (in_d.x >>> step);
      d_next.z = in_d.z + arc_tab(step);
      d_next.u = in_d.u + (in_d.v >>> step);
      d_next.v = in_d.v - (in_d.u >>> step);
    end else begin
      d_next.x = in_d.x - (in_d.y >>> step);
      d_next.y = in_d.y + (in_d.x >>> step);
      d_next.z = in_d.z - arc_tab(step);
      d_next.u = in_d.u - (in_d.v >>> step);
      d_next.v = in_d.v + (in_d.u >>> step);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= d_next;
    end
  end

endmodule
